// ----- hdl/pis_pkg.sv -----
package pis_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int DEF_CAPACITY = 64;
   localparam int DEF_KEY_WIDTH = 32;

   typedef struct packed {
      logic insert;
      logic drain_shift;
   } pis_ctrl_type;

endpackage

// ----- hdl/pis_req_if.sv -----
interface pis_req_if;
   import pis_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] primary_key;
   logic signed [FIELD_WIDTH-1:0] secondary_key;
   logic                          final_item;

   modport source (output valid, output primary_key, output secondary_key,
                   output final_item, input ready);
   modport sink (input valid, input primary_key, input secondary_key,
                 input final_item, output ready);
endinterface

// ----- hdl/pis_rsp_if.sv -----
interface pis_rsp_if;
   import pis_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] out_primary;
   logic signed [FIELD_WIDTH-1:0] out_secondary;
   logic                          end_of_run;
   logic                          overflowed;

   modport source (output valid, output out_primary, output out_secondary,
                   output end_of_run, output overflowed, input ready);
   modport sink (input valid, input out_primary, input out_secondary,
                 input end_of_run, input overflowed, output ready);
endinterface

// ----- hdl/pis_cell.sv -----
module pis_cell #(
   parameter int KEY_WIDTH = pis_pkg::DEF_KEY_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pis_pkg::pis_ctrl_type       ctrl,
   input  logic signed [KEY_WIDTH-1:0] new_primary,
   input  logic signed [KEY_WIDTH-1:0] new_secondary,
   input  logic                        prev_at,
   input  logic signed [KEY_WIDTH-1:0] prev_primary,
   input  logic signed [KEY_WIDTH-1:0] prev_secondary,
   input  logic                        prev_valid,
   input  logic signed [KEY_WIDTH-1:0] next_primary,
   input  logic signed [KEY_WIDTH-1:0] next_secondary,
   input  logic                        next_valid,
   output logic                        at,
   output logic                        valid,
   output logic signed [KEY_WIDTH-1:0] primary,
   output logic signed [KEY_WIDTH-1:0] secondary
);
   import pis_pkg::*;

   logic                        valid_ff, valid_in;
   logic signed [KEY_WIDTH-1:0] primary_ff, primary_in;
   logic signed [KEY_WIDTH-1:0] secondary_ff, secondary_in;
   logic                        greater;

   // stored pair strictly greater than the incoming one
   assign greater = valid_ff && ((primary_ff > new_primary) ||
                    ((primary_ff == new_primary) && (secondary_ff > new_secondary)));
   assign at = greater || !valid_ff;

   always_comb begin
      valid_in     = valid_ff;
      primary_in   = primary_ff;
      secondary_in = secondary_ff;
      if (ctrl.insert && at) begin
         if (prev_at) begin
            valid_in     = prev_valid;
            primary_in   = prev_primary;
            secondary_in = prev_secondary;
         end else begin
            valid_in     = 1'b1;
            primary_in   = new_primary;
            secondary_in = new_secondary;
         end
      end else if (ctrl.drain_shift) begin
         valid_in     = next_valid;
         primary_in   = next_primary;
         secondary_in = next_secondary;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      primary_ff   <= primary_in;
      secondary_ff <= secondary_in;
   end

   assign valid     = valid_ff;
   assign primary   = primary_ff;
   assign secondary = secondary_ff;
endmodule

// ----- hdl/pair_insertion_sorter.sv -----
// channel  dir  handshake            payload
// req      in   valid/ready          primary_key, secondary_key, final_item
// rsp      out  valid/ready          out_primary, out_secondary, end_of_run, overflowed
//
// one request is taken per cycle while a set is being collected; every cell
// compares against the new pair in the same cycle; the cells from the insertion
// point on shift by one slot. a final request starts the drain: cell 0 is the
// output register, one pair per cycle while rsp.ready is high; req.ready is low meanwhile
// synchronous active-high reset empties the chain; no clearing pass
// a stall on rsp holds the chain and the shown pair
module pair_insertion_sorter #(
   parameter int CAPACITY  = pis_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = pis_pkg::DEF_KEY_WIDTH
) (
   input logic clock,
   input logic reset,
   pis_req_if.sink   req,
   pis_rsp_if.source rsp
);
   import pis_pkg::*;

   localparam int EXT_WIDTH = (KEY_WIDTH > FIELD_WIDTH) ? KEY_WIDTH : FIELD_WIDTH;

   logic                        draining_ff, draining_in;
   logic                        overflow_ff, overflow_in;
   pis_ctrl_type                ctrl;
   logic                        accept, full, last_out;
   logic signed [EXT_WIDTH-1:0] ext_primary, ext_secondary;
   logic signed [EXT_WIDTH-1:0] wide_primary, wide_secondary;
   logic signed [KEY_WIDTH-1:0] new_primary, new_secondary;

   logic                        at_w [CAPACITY];
   logic                        valid_w [CAPACITY];
   logic signed [KEY_WIDTH-1:0] primary_w [CAPACITY];
   logic signed [KEY_WIDTH-1:0] secondary_w [CAPACITY];

   // key is the low bits of the field, sign-extended
   assign ext_primary   = EXT_WIDTH'(req.primary_key);
   assign ext_secondary = EXT_WIDTH'(req.secondary_key);
   assign new_primary   = ext_primary[KEY_WIDTH-1:0];
   assign new_secondary = ext_secondary[KEY_WIDTH-1:0];

   assign full     = valid_w[CAPACITY-1];
   assign accept   = req.valid && req.ready;
   assign last_out = rsp.valid && rsp.ready && !valid_w[1];

   assign ctrl.insert      = accept && !full;
   assign ctrl.drain_shift = rsp.valid && rsp.ready;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                        p_at, p_valid, n_valid;
         logic signed [KEY_WIDTH-1:0] p_primary, p_secondary, n_primary, n_secondary;
         if (i == 0) begin : g_first
            assign p_at        = 1'b0;
            assign p_valid     = 1'b0;
            assign p_primary   = '0;
            assign p_secondary = '0;
         end else begin : g_mid
            assign p_at        = at_w[i-1];
            assign p_valid     = valid_w[i-1];
            assign p_primary   = primary_w[i-1];
            assign p_secondary = secondary_w[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign n_valid     = 1'b0;
            assign n_primary   = '0;
            assign n_secondary = '0;
         end else begin : g_body
            assign n_valid     = valid_w[i+1];
            assign n_primary   = primary_w[i+1];
            assign n_secondary = secondary_w[i+1];
         end
         pis_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctrl           (ctrl),
            .new_primary    (new_primary),
            .new_secondary  (new_secondary),
            .prev_at        (p_at),
            .prev_primary   (p_primary),
            .prev_secondary (p_secondary),
            .prev_valid     (p_valid),
            .next_primary   (n_primary),
            .next_secondary (n_secondary),
            .next_valid     (n_valid),
            .at             (at_w[i]),
            .valid          (valid_w[i]),
            .primary        (primary_w[i]),
            .secondary      (secondary_w[i])
         );
      end
   endgenerate

   always_comb begin
      draining_in = draining_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         if (full) begin
            overflow_in = 1'b1;
         end
         if (req.final_item) begin
            draining_in = 1'b1;
         end
      end
      if (last_out) begin
         draining_in = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         overflow_ff <= overflow_in;
      end
   end

   assign wide_primary   = EXT_WIDTH'(primary_w[0]);
   assign wide_secondary = EXT_WIDTH'(secondary_w[0]);

   assign req.ready         = !draining_ff;
   assign rsp.valid         = draining_ff;
   assign rsp.out_primary   = wide_primary[FIELD_WIDTH-1:0];
   assign rsp.out_secondary = wide_secondary[FIELD_WIDTH-1:0];
   assign rsp.end_of_run    = !valid_w[1];
   assign rsp.overflowed    = overflow_ff;
endmodule

// ----- hdl/pis_checker.sv -----
module pis_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_final,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_end
);
   // final request starts the drain
   a_final_drain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_final) |=> (rsp_valid && !req_ready))
      else $error("drain did not start after final request");

   // no requests taken while results are shown
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready during drain");

   // drain ends after the flagged last pair
   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_end) |=> (!rsp_valid && req_ready))
      else $error("drain continued past end of run");

   // non-final request never yields a result
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_final) |=> !rsp_valid)
      else $error("result without final request");

   // stalled result stays valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped under stall");
endmodule

bind pair_insertion_sorter pis_checker u_pis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_final (req.final_item),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_end   (rsp.end_of_run)
);
